FILE: rtl/erpm_pkg.sv
// Shared types and constants for the encoder rpm estimator.
// Used by erpm_ctrl, erpm_dp and the top level encoder_rpm_estimator.
package erpm_pkg;

  // Fixed-point format of the speed value
  localparam int RPM_FRAC_BITS = 8;
  localparam int RPM_W         = 24;

  // Field widths
  localparam int MS_W     = 16;
  localparam int EDGE_W   = 15;
  localparam int TOTAL_W  = 32;
  localparam int SINCE_W  = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIME     = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] COUNTS_PER_REV_RST = 16'd2048;
  localparam logic [CFG_W-1:0] STOP_TIMEOUT_RST   = 16'd500;
  localparam logic [CFG_W-1:0] STUCK_TIME_RST     = 16'd1200;

  // Quotient datapath: numerator is edges * 60000 scaled by 2^F
  localparam int MS_PER_MIN = 60000;
  localparam int PROD_W     = EDGE_W + 16;
  localparam int NUM_W      = PROD_W + RPM_FRAC_BITS;
  localparam int DEN_W      = 2 * MS_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Filter constants
  localparam int DECAY_MUL  = 230;
  localparam int NEAR_MUL   = 100;
  localparam int SNAP_MUL   = 20;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the input word
    logic mul;       // form numerator and denominator, clear the divider
    logic div_step;  // one restoring division step
    logic commit;    // update state and load the result word
  } erpm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // nonzero elapsed time and nonzero edge count
  } erpm_sts_t;

endpackage

FILE: rtl/encoder_rpm_estimator.sv
// Encoder rpm estimator top level: controller plus datapath.
// Depends on erpm_pkg, erpm_ctrl and erpm_dp.
//
// Each input word is one sample period and yields exactly one result word.
// After acceptance, a sample with edges passes through a multiply step that forms
// edges*60000*2^8 and elapsed_ms*counts_per_rev, one restoring-division step
// per numerator bit (39), and a commit step. A sample with no edges or zero
// elapsed time goes from the multiply step straight to commit. The result sits
// in an output register, so the next sample is accepted while it waits;
// a new result commits only once the previous one has been taken.
// Configuration writes are always ready and should be issued only when idle.
module encoder_rpm_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [erpm_pkg::MS_W-1:0]     in_elapsed_ms,
  input  logic [erpm_pkg::EDGE_W-1:0]   in_edge_count,
  input  logic                          in_pin_a_level,
  input  logic                          in_pin_b_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [erpm_pkg::RPM_W-1:0]    out_rpm_q8,
  output logic signed [erpm_pkg::TOTAL_W-1:0] out_edge_total,
  output logic                          out_moving,
  output logic                          out_a_stuck_low,
  output logic                          out_a_stuck_high,
  output logic                          out_b_stuck_low,
  output logic                          out_b_stuck_high,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [erpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erpm_pkg::CFG_W-1:0]    cfg_data
);
  import erpm_pkg::*;

  erpm_cmd_t cmd;
  erpm_sts_t sts;

  assign cfg_ready = 1'b1;

  erpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  erpm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_elapsed_ms    (in_elapsed_ms),
    .in_edge_count    (in_edge_count),
    .in_pin_a_level   (in_pin_a_level),
    .in_pin_b_level   (in_pin_b_level),
    .out_rpm_q8       (out_rpm_q8),
    .out_edge_total   (out_edge_total),
    .out_moving       (out_moving),
    .out_a_stuck_low  (out_a_stuck_low),
    .out_a_stuck_high (out_a_stuck_high),
    .out_b_stuck_low  (out_b_stuck_low),
    .out_b_stuck_high (out_b_stuck_high)
  );

endmodule

FILE: rtl/erpm_ctrl.sv
// Sequencer for the encoder rpm estimator: handshakes, division step count,
// result valid. Depends on erpm_pkg.
module erpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output erpm_pkg::erpm_cmd_t cmd,
  input  erpm_pkg::erpm_sts_t sts
);
  import erpm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  // result slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on commit, held while stalled
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/erpm_dp.sv
// Datapath for the encoder rpm estimator: configuration registers, quotient
// divider, speed filter, edge/pin tracking, result word. Depends on erpm_pkg.
module erpm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erpm_pkg::erpm_cmd_t           cmd,
  output erpm_pkg::erpm_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [erpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erpm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [erpm_pkg::MS_W-1:0]     in_elapsed_ms,
  input  logic [erpm_pkg::EDGE_W-1:0]   in_edge_count,
  input  logic                          in_pin_a_level,
  input  logic                          in_pin_b_level,
  output logic [erpm_pkg::RPM_W-1:0]    out_rpm_q8,
  output logic signed [erpm_pkg::TOTAL_W-1:0] out_edge_total,
  output logic                          out_moving,
  output logic                          out_a_stuck_low,
  output logic                          out_a_stuck_high,
  output logic                          out_b_stuck_low,
  output logic                          out_b_stuck_high
);
  import erpm_pkg::*;

  localparam logic [RPM_W+6:0]  NEAR_LIM = (RPM_W+7)'(1) << RPM_FRAC_BITS;
  localparam logic [RPM_W+4:0]  SNAP_LIM = (RPM_W+5)'(1) << RPM_FRAC_BITS;
  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [MS_W-1:0]    STABLE_MAX = '1;

  // configuration registers
  logic [CFG_W-1:0] epr_r, stop_r, stuck_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epr_r   <= COUNTS_PER_REV_RST;
      stop_r  <= STOP_TIMEOUT_RST;
      stuck_r <= STUCK_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNTS_PER_REV: epr_r   <= cfg_data;
        CFG_STOP_TIMEOUT:   stop_r  <= cfg_data;
        CFG_STUCK_TIME:     stuck_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic [MS_W-1:0]   dt_r;
  logic [EDGE_W-1:0] edges_r;
  logic              a_r, b_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r    <= in_elapsed_ms;
      edges_r <= in_edge_count;
      a_r     <= in_pin_a_level;
      b_r     <= in_pin_b_level;
    end
  end

  assign sts.need_div = (dt_r != '0) && (edges_r != '0);

  // numerator and denominator products
  logic [CFG_W-1:0]  epr_eff;
  logic [PROD_W-1:0] prod_e;
  logic [DEN_W-1:0]  prod_d;

  assign epr_eff = (epr_r == '0) ? CFG_W'(1) : epr_r;
  assign prod_e  = PROD_W'(edges_r) * PROD_W'(MS_PER_MIN);
  assign prod_d  = DEN_W'(dt_r) * DEN_W'(epr_eff);

  // restoring divider, one quotient bit per step, saturating quotient
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [RPM_W-1:0] q_r;
  logic             ovf_r;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r <= {prod_e, {RPM_FRAC_BITS{1'b0}}};
      den_r <= prod_d;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[RPM_W-2:0], ge};
      ovf_r <= ovf_r | q_r[RPM_W-1];
    end
  end

  // estimator state
  logic [RPM_W-1:0]   filt_r, filt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic               seen_r, seen_nxt;
  logic               known_r, known_nxt;
  logic               prev_a_r, prev_a_nxt, prev_b_r, prev_b_nxt;
  logic [MS_W-1:0]    a_st_r, a_st_nxt, b_st_r, b_st_nxt;

  logic [RPM_W-1:0]   inst;
  logic [RPM_W+6:0]   near_prod;
  logic [RPM_W+1:0]   avg_sum;
  logic [RPM_W+7:0]   dec_prod;
  logic [RPM_W-1:0]   dec_val;
  logic [RPM_W+4:0]   snap_prod;
  logic [SINCE_W:0]   since_sum;
  logic [MS_W:0]      a_sum, b_sum;
  logic               a_same, b_same, mv_nxt;

  // speed arithmetic
  assign inst      = ovf_r ? '1 : q_r;
  assign near_prod = (RPM_W+7)'(filt_r) * (RPM_W+7)'(NEAR_MUL);
  assign avg_sum   = (RPM_W+2)'(filt_r) * (RPM_W+2)'(3) + (RPM_W+2)'(inst);
  assign dec_prod  = (RPM_W+8)'(filt_r) * (RPM_W+8)'(DECAY_MUL);
  assign dec_val   = dec_prod[RPM_W+7:8];
  assign snap_prod = (RPM_W+5)'(dec_val) * (RPM_W+5)'(SNAP_MUL);

  // time and pin arithmetic
  assign since_sum = (SINCE_W+1)'(since_r) + (SINCE_W+1)'(dt_r);
  assign a_sum     = (MS_W+1)'(a_st_r) + (MS_W+1)'(dt_r);
  assign b_sum     = (MS_W+1)'(b_st_r) + (MS_W+1)'(dt_r);
  assign a_same    = !known_r || (a_r == prev_a_r);
  assign b_same    = !known_r || (b_r == prev_b_r);

  // next state for one sample
  always_comb begin
    filt_nxt   = filt_r;
    total_nxt  = total_r;
    since_nxt  = since_r;
    seen_nxt   = seen_r;
    known_nxt  = known_r;
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    a_st_nxt   = a_st_r;
    b_st_nxt   = b_st_r;
    if (dt_r != '0) begin
      // pins: latch level, grow or restart stable time
      known_nxt  = 1'b1;
      prev_a_nxt = a_r;
      prev_b_nxt = b_r;
      if (a_same) begin
        a_st_nxt = a_sum[MS_W] ? STABLE_MAX : a_sum[MS_W-1:0];
      end else begin
        a_st_nxt = '0;
      end
      if (b_same) begin
        b_st_nxt = b_sum[MS_W] ? STABLE_MAX : b_sum[MS_W-1:0];
      end else begin
        b_st_nxt = '0;
      end
      if (edges_r != '0) begin
        total_nxt = total_r + TOTAL_W'(edges_r);
        since_nxt = '0;
        seen_nxt  = 1'b1;
        if (near_prod <= NEAR_LIM) begin
          filt_nxt = inst;
        end else begin
          filt_nxt = avg_sum[RPM_W+1:2];
        end
      end else begin
        since_nxt = since_sum[SINCE_W] ? SINCE_MAX : since_sum[SINCE_W-1:0];
      end
    end
  end

  assign mv_nxt = seen_nxt && (since_nxt <= SINCE_W'(stop_r));

  // no-edge decay runs on the updated moving flag
  logic [RPM_W-1:0] filt_fin;
  always_comb begin
    filt_fin = filt_nxt;
    if ((dt_r != '0) && (edges_r == '0)) begin
      if (!mv_nxt || (snap_prod < SNAP_LIM)) begin
        filt_fin = '0;
      end else begin
        filt_fin = dec_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      total_r  <= '0;
      since_r  <= '0;
      seen_r   <= 1'b0;
      known_r  <= 1'b0;
      prev_a_r <= 1'b0;
      prev_b_r <= 1'b0;
      a_st_r   <= '0;
      b_st_r   <= '0;
    end else if (cmd.commit) begin
      filt_r   <= filt_fin;
      total_r  <= total_nxt;
      since_r  <= since_nxt;
      seen_r   <= seen_nxt;
      known_r  <= known_nxt;
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
      a_st_r   <= a_st_nxt;
      b_st_r   <= b_st_nxt;
    end
  end

  // result word register
  logic a_old, b_old;
  assign a_old = mv_nxt && (a_st_nxt >= stuck_r);
  assign b_old = mv_nxt && (b_st_nxt >= stuck_r);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_rpm_q8       <= filt_fin;
      out_edge_total   <= total_nxt;
      out_moving       <= mv_nxt;
      out_a_stuck_low  <= a_old && !prev_a_nxt;
      out_a_stuck_high <= a_old && prev_a_nxt;
      out_b_stuck_low  <= b_old && !prev_b_nxt;
      out_b_stuck_high <= b_old && prev_b_nxt;
    end
  end

endmodule
